[hdl/qau_pkg.sv]
// Package for the quaternion arithmetic unit: widths, record types and helpers.
// Depends on nothing; every other file of the unit refers to it by scoped names.
`timescale 1ns / 1ps

package qau_pkg;

  // Component format and chain lengths.
  localparam int COMP_WIDTH   = 16;
  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_WIDTH  = 16;

  // CORDIC datapath width (Q30 values plus headroom) and step index width.
  localparam int CW  = 34;
  localparam int CIW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // Angle handling widths.
  localparam int HW = ANGLE_WIDTH + 2;
  localparam int ZW = HW + 27;

  // Q30 constants: radians per degree (the 1/128 degree input is shifted down after the multiply), CORDIC start gain.
  localparam longint DEG_RAD_Q30   = 18740331;
  localparam longint CORDIC_X0_Q30 = 652032874;

  // Rounded sine and cosine width.
  localparam int CSW = COMP_WIDTH + 2;

  // Normalization widths.
  localparam int PW        = 2 * COMP_WIDTH - 1;
  localparam int SW        = PW + 2;
  localparam int RW        = SW + 1;
  localparam int QW        = 2 * FRAC_BITS + 1;
  localparam int RSW       = QW + 1;
  localparam int DIV_STEPS = 2 * FRAC_BITS;
  localparam int SQ_STEPS  = FRAC_BITS + 1;
  localparam int SIW       = $clog2(SQ_STEPS);

  // Width used for sums before saturation.
  localparam int SATW = 2 * COMP_WIDTH + 8;

  // Operation codes.
  localparam logic [1:0] MODE_MUL  = 2'd0;
  localparam logic [1:0] MODE_NORM = 2'd1;
  localparam logic [1:0] MODE_AXIS = 2'd2;

  // Item record that travels along the whole pipeline.
  typedef struct packed {
    logic                       valid;
    logic [1:0]                 mode;
    logic [3:0][COMP_WIDTH-1:0] a;
    logic [3:0][COMP_WIDTH-1:0] prod;
    logic                       pclip;
    logic                       vclip;
    logic                       zero;
    logic [3:0]                 neg;
  } qau_tag_t;

  // CORDIC cell state.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } qau_cor_t;

  // Divider cell state, four lanes sharing one divisor.
  typedef struct packed {
    logic [SW-1:0]         s;
    logic [3:0][RW-1:0]    rem;
    logic [3:0][QW-1:0]    q;
  } qau_div_t;

  // Square root cell state, four lanes.
  typedef struct packed {
    logic [3:0][QW-1:0]  x;
    logic [3:0][RSW-1:0] res;
  } qau_sqr_t;

  // Saturated component with its clip flag.
  typedef struct packed {
    logic [COMP_WIDTH-1:0] val;
    logic                  clip;
  } qau_sat_t;

  // Clip a wide signed value to the component range.
  function automatic qau_sat_t qau_sat(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    qau_sat_t               r;
    hi = SATW'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
    lo = -hi - SATW'(1);
    if (v > hi) begin
      r.val  = hi[COMP_WIDTH-1:0];
      r.clip = 1'b1;
    end else if (v < lo) begin
      r.val  = lo[COMP_WIDTH-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[COMP_WIDTH-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Arctangent of 2^-i in Q30; small angles take the shift form.
  function automatic logic signed [CW-1:0] qau_atan(input logic [CIW-1:0] i);
    logic signed [CW-1:0] r;
    logic [5:0]           sa;
    sa = 6'd30 - 6'(i);
    case (i)
      CIW'(0):  r = CW'(64'sd843314857);
      CIW'(1):  r = CW'(64'sd497837829);
      CIW'(2):  r = CW'(64'sd263043837);
      CIW'(3):  r = CW'(64'sd133525159);
      CIW'(4):  r = CW'(64'sd67021687);
      CIW'(5):  r = CW'(64'sd33543516);
      CIW'(6):  r = CW'(64'sd16775851);
      CIW'(7):  r = CW'(64'sd8388437);
      CIW'(8):  r = CW'(64'sd4194283);
      CIW'(9):  r = CW'(64'sd2097149);
      CIW'(10): r = CW'(64'sd1048576);
      default: begin
        if (6'(i) <= 6'd30) begin
          r = CW'(64'd1 << sa);
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/qau_cordic_cell.sv]
// One rotation-mode CORDIC iteration with its output register.
// Depends on qau_pkg for the record types and the arctangent table.
`timescale 1ns / 1ps

module qau_cordic_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [qau_pkg::CIW-1:0] step_i,
  input  qau_pkg::qau_tag_t       tag_i,
  input  qau_pkg::qau_cor_t       cor_i,
  output qau_pkg::qau_tag_t       tag_o,
  output qau_pkg::qau_cor_t       cor_o
);

  logic signed [qau_pkg::CW-1:0] x;
  logic signed [qau_pkg::CW-1:0] y;
  logic signed [qau_pkg::CW-1:0] z;
  logic signed [qau_pkg::CW-1:0] at;
  qau_pkg::qau_cor_t             cor_d;
  qau_pkg::qau_cor_t             cor_q;
  qau_pkg::qau_tag_t             tag_q;

  assign x  = cor_i.x;
  assign y  = cor_i.y;
  assign z  = cor_i.z;
  assign at = qau_pkg::qau_atan(step_i);

  // Rotate toward zero residual angle; shifts are floor shifts.
  always_comb begin
    cor_d.flip = cor_i.flip;
    if (!z[qau_pkg::CW-1]) begin
      cor_d.x = x - (y >>> step_i);
      cor_d.y = y + (x >>> step_i);
      cor_d.z = z - at;
    end else begin
      cor_d.x = x + (y >>> step_i);
      cor_d.y = y - (x >>> step_i);
      cor_d.z = z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      cor_q <= '0;
    end else begin
      tag_q <= tag_i;
      cor_q <= cor_d;
    end
  end

  assign tag_o = tag_q;
  assign cor_o = cor_q;

endmodule

[hdl/qau_div_cell.sv]
// One restoring division step for four lanes that share a divisor.
// Depends on qau_pkg for the record types.
`timescale 1ns / 1ps

module qau_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qau_pkg::qau_tag_t tag_i,
  input  qau_pkg::qau_div_t div_i,
  output qau_pkg::qau_tag_t tag_o,
  output qau_pkg::qau_div_t div_o
);

  qau_pkg::qau_div_t div_d;
  qau_pkg::qau_div_t div_q;
  qau_pkg::qau_tag_t tag_q;

  // Shift the remainder, try the subtract, and shift the quotient bit in.
  always_comb begin
    logic [qau_pkg::RW-1:0] rem2;
    logic                   ge;
    div_d.s   = div_i.s;
    div_d.rem = div_i.rem;
    div_d.q   = div_i.q;
    for (int i = 0; i < 4; i++) begin
      rem2 = {div_i.rem[i][qau_pkg::RW-2:0], 1'b0};
      ge   = (rem2 >= qau_pkg::RW'(div_i.s));
      div_d.rem[i] = ge ? (rem2 - qau_pkg::RW'(div_i.s)) : rem2;
      div_d.q[i]   = {div_i.q[i][qau_pkg::QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      div_q <= '0;
    end else begin
      tag_q <= tag_i;
      div_q <= div_d;
    end
  end

  assign tag_o = tag_q;
  assign div_o = div_q;

endmodule

[hdl/qau_sqrt_cell.sv]
// One digit of a bitwise integer square root for four lanes.
// Depends on qau_pkg for the record types.
`timescale 1ns / 1ps

module qau_sqrt_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [qau_pkg::SIW-1:0] step_i,
  input  qau_pkg::qau_tag_t       tag_i,
  input  qau_pkg::qau_sqr_t       sqr_i,
  output qau_pkg::qau_tag_t       tag_o,
  output qau_pkg::qau_sqr_t       sqr_o
);

  logic [qau_pkg::RSW-1:0] bitv;
  qau_pkg::qau_sqr_t       sqr_d;
  qau_pkg::qau_sqr_t       sqr_q;
  qau_pkg::qau_tag_t       tag_q;

  // The trial bit is a power of four that falls by one digit per cell.
  assign bitv = qau_pkg::RSW'(1) << (2 * (qau_pkg::FRAC_BITS - int'(step_i)));

  always_comb begin
    logic [qau_pkg::RSW-1:0] trial;
    sqr_d = sqr_i;
    for (int i = 0; i < 4; i++) begin
      trial = sqr_i.res[i] + bitv;
      if (qau_pkg::RSW'(sqr_i.x[i]) >= trial) begin
        sqr_d.x[i]   = sqr_i.x[i] - trial[qau_pkg::QW-1:0];
        sqr_d.res[i] = (sqr_i.res[i] >> 1) + bitv;
      end else begin
        sqr_d.res[i] = sqr_i.res[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      sqr_q <= '0;
    end else begin
      tag_q <= tag_i;
      sqr_q <= sqr_d;
    end
  end

  assign tag_o = tag_q;
  assign sqr_o = sqr_q;

endmodule

[hdl/quaternion_arith_unit.sv]
// Quaternion arithmetic unit: Hamilton product, normalization, axis-angle build.
// Depends on qau_pkg and the cells qau_cordic_cell, qau_div_cell, qau_sqrt_cell.
//
//   channel   ports                                   direction  transfer
//   command   start, busy, mode_i, a_*_i, b_*_i,      in         start && !busy
//             angle_deg_i
//   result    valid_o, r_*_o, zero_length_o,          out        valid_o
//             saturated_o
//
// A new command can be taken in every cycle; busy is high only while reset is held
// and in the cycle after it is released. Each result passes through stages 1 to 3,
// the CORDIC cell chain, stages C, V, P, S and D0, the divider and square root cell
// chains and the output register.
// Reset clears all pipeline valid bits; items in flight are dropped.
// The receiver cannot stall: valid_o is a one-cycle strobe per result.
`timescale 1ns / 1ps

module quaternion_arith_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            mode_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  a_x_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  a_y_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  a_z_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  a_w_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  b_x_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  b_y_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  b_z_i,
  input  logic signed [qau_pkg::COMP_WIDTH-1:0]  b_w_i,
  input  logic signed [qau_pkg::ANGLE_WIDTH-1:0] angle_deg_i,
  output logic                                  valid_o,
  output logic signed [qau_pkg::COMP_WIDTH-1:0]  r_x_o,
  output logic signed [qau_pkg::COMP_WIDTH-1:0]  r_y_o,
  output logic signed [qau_pkg::COMP_WIDTH-1:0]  r_z_o,
  output logic signed [qau_pkg::COMP_WIDTH-1:0]  r_w_o,
  output logic                                  zero_length_o,
  output logic                                  saturated_o
);

  localparam int CMPW = qau_pkg::COMP_WIDTH;
  localparam int PRW  = 2 * CMPW;
  localparam int LAT  = 3 + qau_pkg::CORDIC_STEPS + 5 + qau_pkg::DIV_STEPS
                        + qau_pkg::SQ_STEPS + 1;
  localparam int CS_SH = 30 - qau_pkg::FRAC_BITS;

  localparam logic signed [qau_pkg::HW-1:0]   H360 = qau_pkg::HW'(46080);
  localparam logic signed [qau_pkg::HW-1:0]   H180 = qau_pkg::HW'(23040);
  localparam logic signed [qau_pkg::HW-1:0]   H90  = qau_pkg::HW'(11520);
  localparam logic signed [qau_pkg::CW-1:0]   CS_HALF =
    (CS_SH > 0) ? qau_pkg::CW'(64'sd1 <<< (CS_SH - 1)) : '0;
  localparam logic signed [qau_pkg::SATW-1:0] HALF_F =
    qau_pkg::SATW'(64'sd1 <<< (qau_pkg::FRAC_BITS - 1));

  // Start gate: busy only right after reset.
  logic busy_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // Stage 1: command capture.
  qau_pkg::qau_tag_t                 s1_tag_d;
  qau_pkg::qau_tag_t                 s1_tag_q;
  logic [3:0][CMPW-1:0]              s1_b_q;
  logic signed [qau_pkg::ANGLE_WIDTH-1:0] s1_ang_q;

  always_comb begin
    s1_tag_d       = '0;
    s1_tag_d.valid = accept;
    s1_tag_d.mode  = mode_i;
    s1_tag_d.a     = {a_w_i, a_z_i, a_y_i, a_x_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s1_b_q   <= '0;
      s1_ang_q <= '0;
    end else begin
      s1_tag_q <= s1_tag_d;
      s1_b_q   <= {b_w_i, b_z_i, b_y_i, b_x_i};
      s1_ang_q <= angle_deg_i;
    end
  end

  // Stage 2: the sixteen product terms, and the half angle wrapped and folded.
  logic signed [CMPW-1:0] ax, ay, az, aw, bx, by, bz, bw;
  logic signed [PRW-1:0]  prd_d [16];
  logic signed [PRW-1:0]  prd_q [16];
  logic signed [qau_pkg::HW-1:0] h_d;
  logic signed [qau_pkg::HW-1:0] s2_h_q;
  logic                   flip_d;
  logic                   s2_flip_q;
  qau_pkg::qau_tag_t      s2_tag_q;

  assign ax = s1_tag_q.a[0];
  assign ay = s1_tag_q.a[1];
  assign az = s1_tag_q.a[2];
  assign aw = s1_tag_q.a[3];
  assign bx = s1_b_q[0];
  assign by = s1_b_q[1];
  assign bz = s1_b_q[2];
  assign bw = s1_b_q[3];

  always_comb begin
    prd_d[0]  = aw * bx;
    prd_d[1]  = ax * bw;
    prd_d[2]  = ay * bz;
    prd_d[3]  = az * by;
    prd_d[4]  = aw * by;
    prd_d[5]  = ax * bz;
    prd_d[6]  = ay * bw;
    prd_d[7]  = az * bx;
    prd_d[8]  = aw * bz;
    prd_d[9]  = ax * by;
    prd_d[10] = ay * bx;
    prd_d[11] = az * bw;
    prd_d[12] = aw * bw;
    prd_d[13] = ax * bx;
    prd_d[14] = ay * by;
    prd_d[15] = az * bz;
  end

  always_comb begin
    h_d    = qau_pkg::HW'(s1_ang_q);
    flip_d = 1'b0;
    if (h_d > H180) begin
      h_d = h_d - H360;
    end
    if (h_d < -H180) begin
      h_d = h_d + H360;
    end
    if (h_d > H90) begin
      h_d    = h_d - H180;
      flip_d = 1'b1;
    end
    if (h_d < -H90) begin
      h_d    = h_d + H180;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tag_q  <= '0;
      s2_h_q    <= '0;
      s2_flip_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        prd_q[i] <= '0;
      end
    end else begin
      s2_tag_q  <= s1_tag_q;
      s2_h_q    <= h_d;
      s2_flip_q <= flip_d;
      for (int i = 0; i < 16; i++) begin
        prd_q[i] <= prd_d[i];
      end
    end
  end

  // Stage 3: product sums rounded and saturated; angle to Q30 radians.
  logic signed [qau_pkg::SATW-1:0] ps [16];
  logic signed [qau_pkg::SATW-1:0] sum_c [4];
  qau_pkg::qau_sat_t               psat [4];
  logic signed [qau_pkg::ZW-1:0]   zp;
  qau_pkg::qau_tag_t               s3_tag_d;
  qau_pkg::qau_tag_t               s3_tag_q;
  qau_pkg::qau_cor_t               s3_cor_d;
  qau_pkg::qau_cor_t               s3_cor_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ps[i] = qau_pkg::SATW'(prd_q[i]);
    end
    sum_c[0] = ps[0] + ps[1] + ps[2] - ps[3] + HALF_F;
    sum_c[1] = ps[4] - ps[5] + ps[6] + ps[7] + HALF_F;
    sum_c[2] = ps[8] + ps[9] - ps[10] + ps[11] + HALF_F;
    sum_c[3] = ps[12] - ps[13] - ps[14] - ps[15] + HALF_F;
    s3_tag_d       = s2_tag_q;
    s3_tag_d.pclip = 1'b0;
    for (int i = 0; i < 4; i++) begin
      psat[i]          = qau_pkg::qau_sat(sum_c[i] >>> qau_pkg::FRAC_BITS);
      s3_tag_d.prod[i] = psat[i].val;
      s3_tag_d.pclip   = s3_tag_d.pclip | psat[i].clip;
    end
  end

  always_comb begin
    zp = qau_pkg::ZW'(s2_h_q) * qau_pkg::ZW'(qau_pkg::DEG_RAD_Q30) + qau_pkg::ZW'(64);
    s3_cor_d.x    = qau_pkg::CW'(qau_pkg::CORDIC_X0_Q30);
    s3_cor_d.y    = '0;
    s3_cor_d.z    = qau_pkg::CW'(zp >>> 7);
    s3_cor_d.flip = s2_flip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_tag_q <= '0;
      s3_cor_q <= '0;
    end else begin
      s3_tag_q <= s3_tag_d;
      s3_cor_q <= s3_cor_d;
    end
  end

  // CORDIC chain.
  qau_pkg::qau_tag_t ctag_c [qau_pkg::CORDIC_STEPS+1];
  qau_pkg::qau_cor_t cor_c  [qau_pkg::CORDIC_STEPS+1];

  assign ctag_c[0] = s3_tag_q;
  assign cor_c[0]  = s3_cor_q;

  for (genvar k = 0; k < qau_pkg::CORDIC_STEPS; k++) begin : g_cordic
    qau_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (qau_pkg::CIW'(k)),
      .tag_i  (ctag_c[k]),
      .cor_i  (cor_c[k]),
      .tag_o  (ctag_c[k+1]),
      .cor_o  (cor_c[k+1])
    );
  end

  // Stage C: cosine and sine back to the component scale.
  logic signed [qau_pkg::CW-1:0]  cx, cy;
  logic signed [qau_pkg::CSW-1:0] c_q, s_q;
  qau_pkg::qau_tag_t              sc_tag_q;

  assign cx = cor_c[qau_pkg::CORDIC_STEPS].flip ? -cor_c[qau_pkg::CORDIC_STEPS].x
                                                : cor_c[qau_pkg::CORDIC_STEPS].x;
  assign cy = cor_c[qau_pkg::CORDIC_STEPS].flip ? -cor_c[qau_pkg::CORDIC_STEPS].y
                                                : cor_c[qau_pkg::CORDIC_STEPS].y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_tag_q <= '0;
      c_q      <= '0;
      s_q      <= '0;
    end else begin
      sc_tag_q <= ctag_c[qau_pkg::CORDIC_STEPS];
      c_q      <= qau_pkg::CSW'((cx + CS_HALF) >>> CS_SH);
      s_q      <= qau_pkg::CSW'((cy + CS_HALF) >>> CS_SH);
    end
  end

  // Stage V: the vector to normalize, from the operand or from the axis and angle.
  logic signed [CMPW+qau_pkg::CSW-1:0] axs [3];
  qau_pkg::qau_sat_t                   vsat [4];
  logic [3:0][CMPW-1:0]                v_d;
  logic [3:0][CMPW-1:0]                v_q;
  qau_pkg::qau_tag_t                   sv_tag_d;
  qau_pkg::qau_tag_t                   sv_tag_q;

  always_comb begin
    sv_tag_d       = sc_tag_q;
    sv_tag_d.vclip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      axs[i]  = $signed(sc_tag_q.a[i]) * s_q;
      vsat[i] = qau_pkg::qau_sat((qau_pkg::SATW'(axs[i]) + HALF_F)
                                 >>> qau_pkg::FRAC_BITS);
    end
    vsat[3] = qau_pkg::qau_sat(qau_pkg::SATW'(c_q));
    for (int i = 0; i < 4; i++) begin
      if (sc_tag_q.mode == qau_pkg::MODE_AXIS) begin
        v_d[i]         = vsat[i].val;
        sv_tag_d.vclip = sv_tag_d.vclip | vsat[i].clip;
      end else begin
        v_d[i] = sc_tag_q.a[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_tag_q <= '0;
      v_q      <= '0;
    end else begin
      sv_tag_q <= sv_tag_d;
      v_q      <= v_d;
    end
  end

  // Stage P: magnitudes squared and signs.
  logic [3:0][CMPW-1:0]         m;
  logic [3:0][PRW-1:0]          msq;
  logic [3:0][qau_pkg::PW-1:0]  p_q;
  qau_pkg::qau_tag_t            sp_tag_d;
  qau_pkg::qau_tag_t            sp_tag_q;

  always_comb begin
    sp_tag_d = sv_tag_q;
    for (int i = 0; i < 4; i++) begin
      sp_tag_d.neg[i] = v_q[i][CMPW-1];
      m[i]   = v_q[i][CMPW-1] ? (~v_q[i] + CMPW'(1)) : v_q[i];
      msq[i] = m[i] * m[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_tag_q <= '0;
      p_q      <= '0;
    end else begin
      sp_tag_q <= sp_tag_d;
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= msq[i][qau_pkg::PW-1:0];
      end
    end
  end

  // Stage S: squared length and the zero-length check.
  logic [qau_pkg::SW-1:0]      s_sum;
  logic [qau_pkg::SW-1:0]      ss_q;
  logic [3:0][qau_pkg::PW-1:0] sp_q;
  qau_pkg::qau_tag_t           ss_tag_d;
  qau_pkg::qau_tag_t           ss_tag_q;

  always_comb begin
    s_sum = qau_pkg::SW'(p_q[0]) + qau_pkg::SW'(p_q[1])
          + qau_pkg::SW'(p_q[2]) + qau_pkg::SW'(p_q[3]);
    ss_tag_d      = sp_tag_q;
    ss_tag_d.zero = (s_sum == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_tag_q <= '0;
      ss_q     <= '0;
      sp_q     <= '0;
    end else begin
      ss_tag_q <= ss_tag_d;
      ss_q     <= s_sum;
      sp_q     <= p_q;
    end
  end

  // Stage D0: integer quotient bit of m^2 / S, which is zero or one.
  qau_pkg::qau_div_t d0_d;
  qau_pkg::qau_div_t d0_q;
  qau_pkg::qau_tag_t d0_tag_q;

  always_comb begin
    logic ge;
    d0_d.s = ss_q;
    for (int i = 0; i < 4; i++) begin
      ge = (qau_pkg::SW'(sp_q[i]) >= ss_q);
      d0_d.rem[i] = ge ? qau_pkg::RW'(qau_pkg::SW'(sp_q[i]) - ss_q)
                       : qau_pkg::RW'(sp_q[i]);
      d0_d.q[i]   = qau_pkg::QW'(ge);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_tag_q <= '0;
      d0_q     <= '0;
    end else begin
      d0_tag_q <= ss_tag_q;
      d0_q     <= d0_d;
    end
  end

  // Divider chain: one fraction bit per cell.
  qau_pkg::qau_tag_t dtag_c [qau_pkg::DIV_STEPS+1];
  qau_pkg::qau_div_t div_c  [qau_pkg::DIV_STEPS+1];

  assign dtag_c[0] = d0_tag_q;
  assign div_c[0]  = d0_q;

  for (genvar k = 0; k < qau_pkg::DIV_STEPS; k++) begin : g_div
    qau_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (dtag_c[k]),
      .div_i  (div_c[k]),
      .tag_o  (dtag_c[k+1]),
      .div_o  (div_c[k+1])
    );
  end

  // Square root chain on the quotients.
  qau_pkg::qau_tag_t stag_c [qau_pkg::SQ_STEPS+1];
  qau_pkg::qau_sqr_t sqr_c  [qau_pkg::SQ_STEPS+1];

  assign stag_c[0]    = dtag_c[qau_pkg::DIV_STEPS];
  assign sqr_c[0].x   = div_c[qau_pkg::DIV_STEPS].q;
  assign sqr_c[0].res = '0;

  for (genvar k = 0; k < qau_pkg::SQ_STEPS; k++) begin : g_sqrt
    qau_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (qau_pkg::SIW'(k)),
      .tag_i  (stag_c[k]),
      .sqr_i  (sqr_c[k]),
      .tag_o  (stag_c[k+1]),
      .sqr_o  (sqr_c[k+1])
    );
  end

  // Output stage: pick the result by mode, restore signs, set the flags.
  qau_pkg::qau_tag_t    ot;
  logic [3:0][CMPW-1:0] rn;
  logic [3:0][CMPW-1:0] r_d;
  logic [3:0][CMPW-1:0] r_q;
  logic                 zero_d, zero_q;
  logic                 sat_d, sat_q;
  logic                 valid_q;

  assign ot = stag_c[qau_pkg::SQ_STEPS];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rn[i] = ot.neg[i] ? -sqr_c[qau_pkg::SQ_STEPS].res[i][CMPW-1:0]
                        : sqr_c[qau_pkg::SQ_STEPS].res[i][CMPW-1:0];
    end
    case (ot.mode)
      qau_pkg::MODE_MUL: begin
        r_d    = ot.prod;
        zero_d = 1'b0;
        sat_d  = ot.pclip;
      end
      qau_pkg::MODE_NORM: begin
        r_d    = ot.zero ? '0 : rn;
        zero_d = ot.zero;
        sat_d  = 1'b0;
      end
      qau_pkg::MODE_AXIS: begin
        r_d    = ot.zero ? '0 : rn;
        zero_d = ot.zero;
        sat_d  = ot.vclip && !ot.zero;
      end
      default: begin
        r_d    = '0;
        zero_d = 1'b0;
        sat_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      r_q     <= '0;
      zero_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      valid_q <= ot.valid;
      r_q     <= r_d;
      zero_q  <= zero_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o       = valid_q;
  assign r_x_o         = r_q[0];
  assign r_y_o         = r_q[1];
  assign r_z_o         = r_q[2];
  assign r_w_o         = r_q[3];
  assign zero_length_o = zero_q;
  assign saturated_o   = sat_q;

  // Every transfer yields exactly one result a fixed latency later.
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("result missing at pipeline latency");

  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT))
    else $error("result without a matching command");

  // A zero-length result is all zero and never reports clipping.
  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_length_o) |->
      (!saturated_o && r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && r_w_o == '0))
    else $error("zero-length result not cleared");

  // The unit is busy for one cycle at most after reset.
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held after reset");

endmodule

[sim/tb_quaternion_arith_unit.sv]
// Self-checking testbench for the quaternion arithmetic unit.
// Depends on qau_pkg and quaternion_arith_unit; a predictor inside the bench computes results.
`timescale 1ns / 1ps

module tb_quaternion_arith_unit;

  localparam int CWD = qau_pkg::COMP_WIDTH;
  localparam int FB = qau_pkg::FRAC_BITS;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic signed [CWD-1:0] x, y, z, w;
    logic                  zero;
    logic                  clip;
  } quat_res_t;

  typedef struct {
    logic [1:0]        mode;
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic signed [15:0] angle;
    bit                typed;
    quat_res_t         res;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = '0;
  logic signed [CWD-1:0] ax = '0, ay = '0, az = '0, aw = '0;
  logic signed [CWD-1:0] bx = '0, by = '0, bz = '0, bw = '0;
  logic signed [qau_pkg::ANGLE_WIDTH-1:0] angle = '0;
  logic valid;
  logic signed [CWD-1:0] rx, ry, rz, rw;
  logic zero_len, sat_flag;

  quat_res_t expected_q[$];
  int mismatches = 0;
  int stall_cycles = 0;

  quaternion_arith_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .mode_i(mode),
    .a_x_i(ax), .a_y_i(ay), .a_z_i(az), .a_w_i(aw),
    .b_x_i(bx), .b_y_i(by), .b_z_i(bz), .b_w_i(bw), .angle_deg_i(angle),
    .valid_o(valid), .r_x_o(rx), .r_y_o(ry), .r_z_o(rz), .r_w_o(rw),
    .zero_length_o(zero_len), .saturated_o(sat_flag)
  );

  // Clock generation.
  initial begin
    forever #1 clk = ~clk;
  end

  // Clip a wide value to the component range.
  function automatic longint clip_comp(input longint v, inout logic clip);
    longint hi;
    hi = (64'sd1 <<< (CWD - 1)) - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      clip = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale four values to unit length; returns 1 when the length is zero.
  function automatic logic unit_scale(input longint v [4], output longint r [4],
                                      inout logic clip);
    longint unsigned m [4];
    longint unsigned all, s, rem, q;
    longint t;
    all = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      all |= m[i];
    end
    while ((all >> 24) != 0) begin
      all >>= 1;
      for (int i = 0; i < 4; i++) m[i] >>= 1;
    end
    for (int i = 0; i < 4; i++) s += m[i] * m[i];
    if (s == 0) begin
      for (int i = 0; i < 4; i++) r[i] = 0;
      return 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      rem = m[i] * m[i];
      q = rem / s;
      rem = rem % s;
      for (int k = 0; k < 2 * FB; k++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= s) begin
          rem -= s;
          q |= 1;
        end
      end
      t = longint'(int_sqrt(q));
      r[i] = clip_comp((v[i] < 0) ? -t : t, clip);
    end
    return 1'b0;
  endfunction

  // Sine and cosine of the half angle by rotation-mode CORDIC in Q30.
  function automatic void half_angle_sincos(input longint h, output longint c,
                                            output longint s);
    longint atan_tab [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                              33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    longint x, y, z, nx, at;
    bit flip;
    x = qau_pkg::CORDIC_X0_Q30;
    y = 0;
    flip = 0;
    if (h > 23040) h -= 46080;
    if (h < -23040) h += 46080;
    if (h > 11520) begin
      h -= 23040;
      flip = 1;
    end
    if (h < -11520) begin
      h += 23040;
      flip = 1;
    end
    z = (h * qau_pkg::DEG_RAD_Q30 + 64) >>> 7;
    for (int i = 0; i < qau_pkg::CORDIC_STEPS; i++) begin
      at = (i < 11) ? atan_tab[i] : ((i <= 30) ? (64'sd1 <<< (30 - i)) : 0);
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= at;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += at;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Expected result of one command.
  function automatic quat_res_t quat_compute(input op_row_t op);
    quat_res_t res;
    longint a [4], b [4], r [4], v [4];
    longint c, s;
    logic clip, zero;
    clip = 1'b0;
    zero = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'(op.a[i]);
      b[i] = longint'(op.b[i]);
      r[i] = 0;
    end
    case (op.mode)
      qau_pkg::MODE_MUL: begin
        // Hamilton product with a = (x,y,z,w) at indexes 0..3.
        r[0] = clip_comp((a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + 8192) >>> FB, clip);
        r[1] = clip_comp((a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0] + 8192) >>> FB, clip);
        r[2] = clip_comp((a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3] + 8192) >>> FB, clip);
        r[3] = clip_comp((a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2] + 8192) >>> FB, clip);
      end
      qau_pkg::MODE_NORM: begin
        zero = unit_scale(a, r, clip);
      end
      qau_pkg::MODE_AXIS: begin
        half_angle_sincos(longint'(op.angle), c, s);
        c = (c + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
        s = (s + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
        for (int i = 0; i < 3; i++) v[i] = clip_comp((a[i] * s + 8192) >>> FB, clip);
        v[3] = clip_comp(c, clip);
        zero = unit_scale(v, r, clip);
        if (zero) clip = 1'b0;
      end
      default: ;
    endcase
    res.x = CWD'(r[0]);
    res.y = CWD'(r[1]);
    res.z = CWD'(r[2]);
    res.w = CWD'(r[3]);
    res.zero = zero;
    res.clip = clip;
    return res;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // Result checker and stall watchdog.
  always @(posedge clk) begin
    quat_res_t e;
    if (rst_n && valid) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (rx !== e.x) report("r_x", rx, e.x);
        if (ry !== e.y) report("r_y", ry, e.y);
        if (rz !== e.z) report("r_z", rz, e.z);
        if (rw !== e.w) report("r_w", rw, e.w);
        if (zero_len !== e.zero) report("zero_length", zero_len, e.zero);
        if (sat_flag !== e.clip) report("saturated", sat_flag, e.clip);
      end
    end
    if ((start && !busy) || valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one command and record its expected result once the transfer happens.
  task automatic send_op(input op_row_t op, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    mode = op.mode;
    ax = op.a[0]; ay = op.a[1]; az = op.a[2]; aw = op.a[3];
    bx = op.b[0]; by = op.b[1]; bz = op.b[2]; bw = op.b[3];
    angle = op.angle;
    do @(posedge clk); while (busy);
    expected_q.push_back(op.typed ? op.res : quat_compute(op));
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic op_row_t make_row(input logic [1:0] m, input logic signed [15:0] a0,
      input logic signed [15:0] a1, input logic signed [15:0] a2, input logic signed [15:0] a3,
      input logic signed [15:0] bv, input logic signed [15:0] ang);
    op_row_t op;
    op.mode = m;
    op.a = '{a0, a1, a2, a3};
    op.b = '{bv, bv, bv, bv};
    op.angle = ang;
    op.typed = 0;
    op.res = '{default: 0};
    return op;
  endfunction

  initial begin
    op_row_t rows [$];
    op_row_t op;
    int idle_pct;

    // Directed rows; typed expectations only where they are plain to see.
    op = make_row(qau_pkg::MODE_MUL, 0, 0, 0, 0, 0, 0);
    op.typed = 1; rows.push_back(op);
    op = make_row(qau_pkg::MODE_MUL, 0, 0, 0, 16'sh8000, 0, 0);
    op.b = '{0, 0, 0, 16'sh8000}; op.typed = 1; op.res.w = 16'sh7fff; op.res.clip = 1;
    rows.push_back(op);
    op = make_row(qau_pkg::MODE_MUL, 0, 0, 0, 16384, 0, 0);
    op.b = '{100, -200, 300, -400}; op.typed = 1;
    op.res = '{100, -200, 300, -400, 0, 0}; rows.push_back(op);
    rows.push_back(make_row(qau_pkg::MODE_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                            16'sh7fff, 0));
    rows.push_back(make_row(qau_pkg::MODE_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh7fff, 0));
    rows.push_back(make_row(qau_pkg::MODE_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                            16'sh8000, 16'sh7fff));
    op = make_row(qau_pkg::MODE_NORM, 0, 0, 0, 0, 16'sh7fff, 16'sh7fff);
    op.typed = 1; op.res.zero = 1; rows.push_back(op);
    op = make_row(qau_pkg::MODE_NORM, 0, 0, 0, 16384, 5, 5);
    op.typed = 1; op.res.w = 16384; rows.push_back(op);
    rows.push_back(make_row(qau_pkg::MODE_NORM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0));
    rows.push_back(make_row(qau_pkg::MODE_NORM, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0));
    rows.push_back(make_row(qau_pkg::MODE_NORM, 16'sh8000, 0, 0, 0, 0, 0));
    rows.push_back(make_row(qau_pkg::MODE_NORM, 1, -1, 0, 0, 0, 0));
    // Axis-angle: a zero axis at a half angle of ninety degrees has zero length.
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 0, 0, 0, 9, 3, 11520));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 0, 0, 0, 0, 0, -11520));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 16384, 0, 0, 0, 0, 0));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 0, 16384, 0, 0, 0, 5760));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 16'sh7fff));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 16'sh8000));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 100, -50, 16'sh8000, 0, 0, 23040));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, -3, 7, 16'sh7fff, 0, 0, -23040));
    rows.push_back(make_row(qau_pkg::MODE_AXIS, 16'sh7fff, 0, 0, 0, 0, 11521));
    op = make_row(MODE_SPARE, 16'sh7fff, 16'sh8000, 1, -1, 16'sh7fff, 16'sh8000);
    op.typed = 1; rows.push_back(op);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_op(rows[i], 0);

    // Random commands in phases of sender idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 66;
        2: idle_pct = 20;
        default: idle_pct = 0;
      endcase
      repeat (108) begin
        op.mode = ($urandom_range(19) == 0) ? MODE_SPARE : 2'($urandom_range(2));
        for (int i = 0; i < 4; i++) begin
          op.a[i] = rand_field();
          op.b[i] = rand_field();
        end
        // For a random half of the axis commands the axis fields are made small, so the product stays in range.
        if (op.mode == qau_pkg::MODE_AXIS && $urandom_range(1))
          for (int i = 0; i < 3; i++) op.a[i] = 16'($signed($urandom_range(2000)) - 1000);
        op.angle = rand_field();
        op.typed = 0;
        send_op(op, idle_pct);
      end
    end
    @(negedge clk);
    start = 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
